// ----- src/mhpq_pkg.sv -----
// Package for the max-heap priority queue.
// Holds operation and status codes, depth default and controller types.
package mhpq_pkg;

  localparam int unsigned DefHeapDepth = 16;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_EXTRACT = 2'd1,
    MODE_INCR    = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_SMALLER  = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LAST_RD,
    S_LAST_LD,
    S_IK_RD,
    S_IK_CMP,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic start_op;
    logic rd_last;
    logic load_last;
    logic rd_idx;
    logic set_smaller;
    logic load_key;
    logic up_root;
    logic rd_parent;
    logic up_eval;
    logic rd_children;
    logic dn_eval;
  } cmd_t;

  typedef struct packed {
    logic  err;
    mode_e mode;
    logic  cnt_zero;
    logic  key_lt;
    logic  pos_zero;
    logic  up_swap;
    logic  dn_swap;
  } stat_t;

endpackage

// ----- src/mhpq_ctrl.sv -----
// Controller state machine of the max-heap priority queue.
// Depends on mhpq_pkg; drives the datapath through cmd_t, reads stat_t.
module mhpq_ctrl import mhpq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o,
  output logic  valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (start_i) state_d = S_DECODE;
      S_DECODE: begin
        if (stat_i.err) begin
          state_d = S_DONE;
        end else begin
          case (stat_i.mode)
            MODE_INSERT:  state_d = S_UP_RD;
            MODE_EXTRACT: state_d = stat_i.cnt_zero ? S_DONE : S_LAST_RD;
            MODE_INCR:    state_d = S_IK_RD;
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_LAST_RD: state_d = S_LAST_LD;
      S_LAST_LD: state_d = S_DN_RD;
      S_IK_RD:   state_d = S_IK_CMP;
      S_IK_CMP:  state_d = stat_i.key_lt ? S_DONE : S_UP_RD;
      S_UP_RD:   state_d = stat_i.pos_zero ? S_DONE : S_UP_CMP;
      S_UP_CMP:  state_d = stat_i.up_swap ? S_UP_RD : S_DONE;
      S_DN_RD:   state_d = S_DN_CMP;
      S_DN_CMP:  state_d = stat_i.dn_swap ? S_DN_RD : S_DONE;
      S_DONE:    state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = (state_q != S_IDLE);
    valid_o = (state_q == S_DONE);
    case (state_q)
      S_IDLE:    cmd_o.start_op = start_i;
      S_LAST_RD: cmd_o.rd_last = 1'b1;
      S_LAST_LD: cmd_o.load_last = 1'b1;
      S_IK_RD:   cmd_o.rd_idx = 1'b1;
      S_IK_CMP: begin
        cmd_o.set_smaller = stat_i.key_lt;
        cmd_o.load_key = !stat_i.key_lt;
      end
      S_UP_RD: begin
        cmd_o.up_root = stat_i.pos_zero;
        cmd_o.rd_parent = !stat_i.pos_zero;
      end
      S_UP_CMP:  cmd_o.up_eval = 1'b1;
      S_DN_RD:   cmd_o.rd_children = 1'b1;
      S_DN_CMP:  cmd_o.dn_eval = 1'b1;
      default:   cmd_o = '0;
    endcase
  end

endmodule

// ----- src/mhpq_dp.sv -----
// Datapath of the max-heap priority queue: heap memory, count, sift registers.
// Depends on mhpq_pkg; commanded by mhpq_ctrl.
module mhpq_dp import mhpq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = DefHeapDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] key_value_i,
  input  logic [3:0]         heap_index_i,
  output logic signed [31:0] extracted_value_o,
  output logic signed [31:0] top_value_o,
  output logic               top_valid_o,
  output logic [4:0]         entry_count_o,
  output logic [2:0]         status_o
);

  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned XW = (CW > 4) ? CW : 4;
  localparam int unsigned KW = CW + 1;

  logic signed [31:0] mem [HEAP_DEPTH];
  logic signed [31:0] rd0_q, rd1_q;
  logic [AW-1:0]      ra0, ra1;
  logic               we;
  logic [AW-1:0]      wa;
  logic signed [31:0] wd;

  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic signed [31:0] cur_q, cur_d;
  logic signed [31:0] key_q;
  logic [AW-1:0]      idx_q;
  mode_e              mode_q;
  logic               err_q, err_d;
  status_e            stat_q, stat_d;
  logic signed [31:0] ext_q, ext_d;
  logic signed [31:0] top_q;
  logic               l_ok_q, r_ok_q;
  logic [AW-1:0]      l_pos_q, r_pos_q;

  logic [KW-1:0]      l_w, r_w;
  logic [AW-1:0]      parent;
  logic               l_big, r_big;
  logic               full, empty, oob;

  assign full   = (count_q >= CW'(HEAP_DEPTH));
  assign empty  = (count_q == '0);
  assign oob    = (XW'(heap_index_i) >= XW'(count_q));
  assign parent = AW'((pos_q - AW'(1)) >> 1);
  assign l_w    = KW'({pos_q, 1'b1});
  assign r_w    = KW'({pos_q, 1'b0}) + KW'(2);

  // The right child only wins if it beats both the held value and a valid left child.
  assign l_big  = l_ok_q && (rd0_q > cur_q);
  assign r_big  = r_ok_q && (rd1_q > (l_big ? rd0_q : cur_q));

  always_comb begin
    ra0 = '0;
    ra1 = '0;
    if (cmd_i.rd_last) ra0 = AW'(count_q);
    if (cmd_i.rd_idx) ra0 = idx_q;
    if (cmd_i.rd_parent) ra0 = parent;
    if (cmd_i.rd_children) begin
      ra0 = l_w[AW-1:0];
      ra1 = r_w[AW-1:0];
    end
  end

  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    cur_d   = cur_q;
    err_d   = err_q;
    stat_d  = stat_q;
    ext_d   = ext_q;
    we      = 1'b0;
    wa      = pos_q;
    wd      = cur_q;
    if (cmd_i.start_op) begin
      err_d  = 1'b0;
      stat_d = ST_OK;
      ext_d  = '0;
      cur_d  = key_value_i;
      case (mode_e'(mode_i))
        MODE_INSERT: begin
          if (full) begin
            err_d  = 1'b1;
            stat_d = ST_OVERFLOW;
          end else begin
            pos_d   = AW'(count_q);
            count_d = count_q + CW'(1);
          end
        end
        MODE_EXTRACT: begin
          if (empty) begin
            err_d  = 1'b1;
            stat_d = ST_EMPTY;
          end else begin
            ext_d   = top_q;
            count_d = count_q - CW'(1);
          end
        end
        MODE_INCR: begin
          if (oob) begin
            err_d  = 1'b1;
            stat_d = ST_RANGE;
          end
        end
        default: err_d = 1'b1;
      endcase
    end
    if (cmd_i.load_last) begin
      cur_d = rd0_q;
      pos_d = '0;
    end
    if (cmd_i.set_smaller) stat_d = ST_SMALLER;
    if (cmd_i.load_key) begin
      cur_d = key_q;
      pos_d = idx_q;
    end
    if (cmd_i.up_root) begin
      we = 1'b1;
    end
    if (cmd_i.up_eval) begin
      we = 1'b1;
      if (rd0_q < cur_q) begin
        wd    = rd0_q;
        pos_d = parent;
      end
    end
    if (cmd_i.dn_eval) begin
      we = 1'b1;
      if (r_big) begin
        wd    = rd1_q;
        pos_d = r_pos_q;
      end else if (l_big) begin
        wd    = rd0_q;
        pos_d = l_pos_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd0_q <= mem[ra0];
    rd1_q <= mem[ra1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    cur_q  <= cur_d;
    err_q  <= err_d;
    stat_q <= stat_d;
    ext_q  <= ext_d;
    if (cmd_i.start_op) begin
      key_q  <= key_value_i;
      idx_q  <= AW'(heap_index_i);
      mode_q <= mode_e'(mode_i);
    end
    if (we && wa == '0) top_q <= wd;
    if (cmd_i.rd_children) begin
      l_ok_q  <= (l_w < KW'(count_q));
      r_ok_q  <= (r_w < KW'(count_q));
      l_pos_q <= l_w[AW-1:0];
      r_pos_q <= r_w[AW-1:0];
    end
  end

  assign stat_o.err      = err_q;
  assign stat_o.mode     = mode_q;
  assign stat_o.cnt_zero = empty;
  assign stat_o.key_lt   = (key_q < rd0_q);
  assign stat_o.pos_zero = (pos_q == '0);
  assign stat_o.up_swap  = (rd0_q < cur_q);
  assign stat_o.dn_swap  = l_big || r_big;

  assign extracted_value_o = ext_q;
  assign top_valid_o       = !empty;
  assign top_value_o       = empty ? 32'sd0 : top_q;
  assign entry_count_o     = 5'(count_q);
  assign status_o          = stat_q;

endmodule

// ----- src/max_heap_priority_queue.sv -----
// Top level of the max-heap priority queue: controller plus datapath.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_dp.
//
//  channel   handshake            payload
//  command   start_i / busy_o     mode_i, key_value_i, heap_index_i
//  result    valid_o strobe       extracted_value_o, top_value_o, top_valid_o,
//                                 entry_count_o, status_o
//
// One operation at a time; busy_o is high from acceptance to the result strobe.
// After acceptance, insert sifts up from the new leaf, extract loads the last entry into the
// root and sifts down, and increase-key reads the indexed entry, compares the keys and then
// sifts up; each sift level is one memory read and one compare-and-write. Errors, no-ops
// and an extract that empties the heap go from decode straight to the result strobe; a
// smaller key strobes after the read and compare. The next command is taken once the
// controller is back in idle after the strobe. Reset empties the heap at once.
// The result is shown for one cycle and cannot be stalled.
module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = DefHeapDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] key_value_i,
  input  logic [3:0]         heap_index_i,
  output logic               valid_o,
  output logic signed [31:0] extracted_value_o,
  output logic signed [31:0] top_value_o,
  output logic               top_valid_o,
  output logic [4:0]         entry_count_o,
  output logic [2:0]         status_o
);

  cmd_t  cmd;
  stat_t stat;

  mhpq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .valid_o (valid_o)
  );

  mhpq_dp #(.HEAP_DEPTH(HEAP_DEPTH)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .mode_i            (mode_i),
    .key_value_i       (key_value_i),
    .heap_index_i      (heap_index_i),
    .extracted_value_o (extracted_value_o),
    .top_value_o       (top_value_o),
    .top_valid_o       (top_valid_o),
    .entry_count_o     (entry_count_o),
    .status_o          (status_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted command did not raise busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_top_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (top_valid_o == (entry_count_o != 5'd0)))
    else $error("top_valid disagrees with entry count");

  a_extract_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_OK) |-> (extracted_value_o == 32'sd0))
    else $error("extracted value on a failed operation");

endmodule
